[rtl/lphs_pkg.sv]
// Shared constants, codes and types of the linear-probe hash set.
package lphs_pkg;

    localparam int ENTRY_SLOTS = 1024;
    localparam int TABLE_SLOTS = 2048;

    localparam int ENT_AW  = $clog2(ENTRY_SLOTS);
    localparam int TAB_AW  = $clog2(TABLE_SLOTS);
    localparam int CNT_W   = ENT_AW + 1;
    localparam int REF_W   = CNT_W;
    localparam int LIMIT_W = 11;
    localparam int KEY_W   = 64;
    localparam int PAR_W   = 10;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

    // hash mix constants
    localparam logic [63:0] MIX_A = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_B = 64'h632BE59BD9B4E019;
    localparam logic [63:0] MIX_C = 64'hC2B2AE3D27D4EB4F;
    localparam int MIX_SHIFT = 29;

    // only the low hash bits that reach the slot index are formed
    localparam int HASH_W = TAB_AW + MIX_SHIFT;
    localparam int MUL_K  = HASH_W - 32;

    // register word index
    localparam logic REG_ENTRY_LIMIT = 1'b0;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_READ     = 3'd3,
        ST_UNFILLED = 3'd4
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [TAB_AW-1:0] slot;
    } t_hash_res;

    typedef struct packed {
        logic [KEY_W-1:0] key_high;
        logic [KEY_W-1:0] key_low;
        logic [PAR_W-1:0] parent;
    } t_entry;

endpackage

[rtl/linear_probe_hash_set_insert_top.sv]
// Top level of the linear-probe hash set: probe table, key store, control and APB register.
//
//  channel   | handshake               | word
//  ----------+-------------------------+---------------------------------------------
//  command   | start / busy            | opcode, key_low/high, parent_index, read_index
//  result    | o_done (one-cycle pulse)| status, entry_index, read key/parent, count
//  register  | APB psel/penable/pwrite | entry_limit at byte address 0
//
// Read: the key store is read, then o_done. Insert: the key is hashed, then
// table slots are read in turn; each occupied slot adds a key store read and
// compare, an equal key ends the walk (each step is a synchronous memory read).
// After reset a clearing pass writes all 2048 probe table slots, one per
// cycle; busy stays high until the pass ends (register writes still work).
// The receiver cannot stall: each result is a single o_done cycle.
module linear_probe_hash_set_insert_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_opcode,
    input  logic [lphs_pkg::KEY_W-1:0]     i_key_low,
    input  logic [lphs_pkg::KEY_W-1:0]     i_key_high,
    input  logic [lphs_pkg::ENT_AW-1:0]    i_parent_index,
    input  logic [lphs_pkg::ENT_AW-1:0]    i_read_index,
    // result
    output logic                           o_done,
    output logic [2:0]                     o_status,
    output logic [lphs_pkg::ENT_AW-1:0]    o_entry_index,
    output logic [lphs_pkg::KEY_W-1:0]     o_read_key_low,
    output logic [lphs_pkg::KEY_W-1:0]     o_read_key_high,
    output logic [lphs_pkg::ENT_AW-1:0]    o_read_parent,
    output logic [lphs_pkg::CNT_W-1:0]     o_entry_count,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import lphs_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_HASH  = 6'b001000,
        S_PROBE = 6'b010000,
        S_CMP   = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic [TAB_AW-1:0]    r_slot, n_slot;
    logic [TAB_AW-1:0]    r_visits, n_visits;
    logic [TAB_AW-1:0]    r_clr, n_clr;
    logic [LIMIT_W-1:0]   r_entry_limit;

    // captured command word
    logic [KEY_W-1:0]     r_klo, r_khi;
    logic [PAR_W-1:0]     r_par;
    logic [ENT_AW-1:0]    r_ridx;

    // result word
    logic                 r_done, n_done;
    t_status              r_status, n_status;
    logic [ENT_AW-1:0]    r_eidx, n_eidx;
    logic [KEY_W-1:0]     r_rlo, n_rlo;
    logic [KEY_W-1:0]     r_rhi, n_rhi;
    logic [PAR_W-1:0]     r_rpar, n_rpar;
    logic [CNT_W-1:0]     r_count, n_count;

    // probe table: 0 empty, else entry index plus one
    logic [REF_W-1:0]     tab_mem [TABLE_SLOTS];
    logic [REF_W-1:0]     r_tab_q;
    logic                 tab_we, tab_re;
    logic [TAB_AW-1:0]    tab_addr;
    logic [REF_W-1:0]     tab_wdata;

    // key store
    t_entry               ent_mem [ENTRY_SLOTS];
    t_entry               r_ent_q;
    t_entry               ent_wdata;
    logic                 ent_we, ent_re;
    logic [ENT_AW-1:0]    ent_waddr, ent_raddr;

    t_hash_res            hash_res;
    logic                 accept;
    logic                 lim_reached;
    logic [REF_W-1:0]     ref_idx;
    logic                 advance;
    logic                 fin;
    t_status              fin_st;
    logic                 cfg_wr;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    lphs_hash u_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (accept && (i_opcode == OP_INSERT)),
        .i_key_low  (i_key_low),
        .i_key_high (i_key_high),
        .o_res      (hash_res)
    );

    // APB: single register, zero-wait
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENTRY_LIMIT);
    assign prdata = (paddr[2] == REG_ENTRY_LIMIT) ? 32'(r_entry_limit) : 32'b0;

    // limit is min(entry_limit, ENTRY_SLOTS)
    assign lim_reached = (32'(r_fill) >= 32'(r_entry_limit)) ||
                         (32'(r_fill) >= 32'(ENTRY_SLOTS));
    assign ref_idx     = r_tab_q - REF_W'(1);

    assign ent_wdata = '{key_high: r_khi, key_low: r_klo, parent: r_par};
    assign ent_waddr = r_fill[ENT_AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_slot    = r_slot;
        n_visits  = r_visits;
        n_clr     = r_clr;
        n_done    = 1'b0;
        n_status  = r_status;
        n_eidx    = r_eidx;
        n_rlo     = r_rlo;
        n_rhi     = r_rhi;
        n_rpar    = r_rpar;
        n_count   = r_count;
        tab_we    = 1'b0;
        tab_re    = 1'b0;
        tab_addr  = r_slot;
        tab_wdata = '0;
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        ent_raddr = i_read_index;
        advance   = 1'b0;
        fin       = 1'b0;
        fin_st    = ST_FULL;

        case (r_state)
            S_CLEAR: begin
                tab_we   = 1'b1;
                tab_addr = r_clr;
                n_clr    = r_clr + TAB_AW'(1);
                if (r_clr == TAB_AW'(TABLE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_READ) begin
                        ent_re  = 1'b1;
                        n_state = S_READ;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_READ: begin
                n_done  = 1'b1;
                n_eidx  = '0;
                n_count = r_fill;
                n_state = S_IDLE;
                if (CNT_W'(r_ridx) < r_fill) begin
                    n_status = ST_READ;
                    n_rlo    = r_ent_q.key_low;
                    n_rhi    = r_ent_q.key_high;
                    n_rpar   = r_ent_q.parent;
                end else begin
                    n_status = ST_UNFILLED;
                    n_rlo    = '0;
                    n_rhi    = '0;
                    n_rpar   = '0;
                end
            end
            S_HASH: begin
                if (hash_res.valid) begin
                    tab_re   = 1'b1;
                    tab_addr = hash_res.slot;
                    n_slot   = hash_res.slot;
                    n_visits = '0;
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_tab_q == '0) begin
                    if (lim_reached) begin
                        fin    = 1'b1;
                        fin_st = ST_FULL;
                    end else begin
                        // claim the empty slot for a new entry
                        tab_we    = 1'b1;
                        tab_addr  = r_slot;
                        tab_wdata = r_fill + REF_W'(1);
                        ent_we    = 1'b1;
                        n_fill    = r_fill + CNT_W'(1);
                        n_done    = 1'b1;
                        n_status  = ST_INSERTED;
                        n_eidx    = r_fill[ENT_AW-1:0];
                        n_rlo     = '0;
                        n_rhi     = '0;
                        n_rpar    = '0;
                        n_count   = r_fill + CNT_W'(1);
                        n_state   = S_IDLE;
                    end
                end else if (ref_idx < r_fill) begin
                    ent_re    = 1'b1;
                    ent_raddr = ref_idx[ENT_AW-1:0];
                    n_state   = S_CMP;
                end else begin
                    advance = 1'b1;
                end
            end
            S_CMP: begin
                if ((r_ent_q.key_low == r_klo) && (r_ent_q.key_high == r_khi)) begin
                    fin    = 1'b1;
                    fin_st = ST_PRESENT;
                end else begin
                    advance = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // step to the next slot; a walk over the whole table means full
        if (advance) begin
            if (r_visits == TAB_AW'(TABLE_SLOTS - 1)) begin
                fin    = 1'b1;
                fin_st = ST_FULL;
            end else begin
                n_visits = r_visits + TAB_AW'(1);
                n_slot   = r_slot + TAB_AW'(1);
                tab_re   = 1'b1;
                tab_addr = r_slot + TAB_AW'(1);
                n_state  = S_PROBE;
            end
        end

        if (fin) begin
            n_done   = 1'b1;
            n_status = fin_st;
            n_eidx   = '0;
            n_rlo    = '0;
            n_rhi    = '0;
            n_rpar   = '0;
            n_count  = r_fill;
            n_state  = S_IDLE;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            tab_mem[tab_addr] <= tab_wdata;
        end
        if (tab_re) begin
            r_tab_q <= tab_mem[tab_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            r_ent_q <= ent_mem[ent_raddr];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_fill        <= '0;
            r_clr         <= '0;
            r_done        <= 1'b0;
            r_entry_limit <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_clr   <= n_clr;
            r_done  <= n_done;
            if (cfg_wr) begin
                r_entry_limit <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_visits <= n_visits;
        r_status <= n_status;
        r_eidx   <= n_eidx;
        r_rlo    <= n_rlo;
        r_rhi    <= n_rhi;
        r_rpar   <= n_rpar;
        r_count  <= n_count;
        if (accept) begin
            r_klo  <= i_key_low;
            r_khi  <= i_key_high;
            r_par  <= i_parent_index;
            r_ridx <= i_read_index;
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_entry_index   = r_eidx;
    assign o_read_key_low  = r_rlo;
    assign o_read_key_high = r_rhi;
    assign o_read_parent   = r_rpar;
    assign o_entry_count   = r_count;

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(ENTRY_SLOTS))
        else $error("fill count above entry store size");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("two result words in consecutive cycles");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_status == ST_INSERTED)) |-> (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("insert result without fill increment");

    a_fill_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fill != $past(r_fill))) |->
        (r_done && (r_status == ST_INSERTED)))
        else $error("fill count changed without insert result");

endmodule

[rtl/lphs_hash.sv]
// Three-stage multiply-xor key hash, reduced to a probe table slot.
module lphs_hash (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic [lphs_pkg::KEY_W-1:0]     i_key_low,
    input  logic [lphs_pkg::KEY_W-1:0]     i_key_high,
    output lphs_pkg::t_hash_res            o_res
);
    import lphs_pkg::*;

    logic [HASH_W-1:0] r_pa;
    logic [HASH_W-1:0] r_sb;
    logic [HASH_W-1:0] r_ha;
    logic [HASH_W-1:0] r_pb;
    logic [MUL_K-1:0]  r_xa;
    logic [MUL_K-1:0]  r_xb;
    logic [2:0]        r_vld;
    logic [TAB_AW-1:0] r_slot;
    logic [HASH_W-1:0] hb;
    logic [HASH_W-1:0] h;

    // low product = a0*b0 + (a0*b1 + a1*b0) << 32; cross terms only need MUL_K bits
    always_ff @(posedge i_clk) begin
        r_pa <= HASH_W'(i_key_low[31:0]) * HASH_W'(MIX_A[31:0]);
        r_xa <= i_key_low[MUL_K-1:0] * MIX_A[HASH_W-1:32]
              + i_key_low[HASH_W-1:32] * MIX_A[MUL_K-1:0];
        r_sb <= i_key_high[HASH_W-1:0] + MIX_B[HASH_W-1:0];

        r_pb <= HASH_W'(r_sb[31:0]) * HASH_W'(MIX_C[31:0]);
        r_xb <= r_sb[MUL_K-1:0] * MIX_C[HASH_W-1:32]
              + r_sb[HASH_W-1:32] * MIX_C[MUL_K-1:0];
        r_ha <= r_pa + {r_xa, 32'b0};

        r_slot <= h[TAB_AW-1:0] ^ h[HASH_W-1:MIX_SHIFT];
    end

    assign hb = r_pb + {r_xb, 32'b0};
    assign h  = r_ha ^ hb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_go};
        end
    end

    assign o_res.valid = r_vld[2];
    assign o_res.slot  = r_slot;

endmodule
